// ===== hdl/bpfrct_pkg.sv =====
package bpfrct_pkg;

  localparam int MAX_STATEMENTS = 1024;
  localparam int SCRATCH_WORDS  = 16;
  localparam int NUM_SLOTS      = 2 + SCRATCH_WORDS;
  localparam int SLOT_W         = $clog2(NUM_SLOTS);
  localparam int CLS_W          = 2 * NUM_SLOTS;
  localparam int ADDR_W         = $clog2(MAX_STATEMENTS);
  localparam int IDX_W          = 10;
  localparam int SUCC_W         = IDX_W + 1;
  localparam int ARCH_W         = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_ARCH  = 2'd1;
  localparam logic [1:0] CLS_SYSNR = 2'd2;
  localparam logic [1:0] CLS_MIXED = 2'd3;

  localparam logic [ARCH_W-1:0] ARCH_NONE  = ARCH_W'(0);
  localparam logic [ARCH_W-1:0] ARCH_MIXED = ARCH_W'(3);

  localparam logic [1:0] OPND_NONE  = 2'd0;
  localparam logic [1:0] OPND_ARCH  = 2'd1;
  localparam logic [1:0] OPND_SYSNR = 2'd2;

  localparam logic [1:0] DST_A   = 2'd0;
  localparam logic [1:0] DST_X   = 2'd1;
  localparam logic [1:0] DST_MEM = 2'd2;

  localparam logic [2:0] SRC_A     = 3'd0;
  localparam logic [2:0] SRC_X     = 3'd1;
  localparam logic [2:0] SRC_MEM   = 3'd2;
  localparam logic [2:0] SRC_SYSNR = 3'd3;
  localparam logic [2:0] SRC_ARCH  = 3'd4;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_NE = 2'd1;

  localparam logic [SLOT_W-1:0] SLOT_A   = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_X   = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_MEM = SLOT_W'(2);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_JUMP   = 2'd2,
    OP_RETURN = 2'd3
  } op_e;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    op_e               op;
    logic              pc_ok;
    addr_t             pc;
    logic              err;
    addr_t             succ1;
    logic              succ1_ok;
    addr_t             succ2;
    logic              succ2_ok;
    logic              cond;
    logic [1:0]        cmp;
    logic [ARCH_W-1:0] cval;
    logic              dst_en;
    logic [SLOT_W-1:0] dst_slot;
    logic              src_en;
    logic [SLOT_W-1:0] src_slot;
    logic [1:0]        src_cls;
  } cmd_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [ARCH_W-1:0] arch;
  } entry_t;

  function automatic logic [1:0] merge_one(logic [1:0] d, logic [1:0] s);
    logic [1:0] r;
    if (d == CLS_NONE) begin
      r = s;
    end else if (d != s) begin
      r = CLS_MIXED;
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [CLS_W-1:0] merge_cls(logic [CLS_W-1:0] d, logic [CLS_W-1:0] s);
    logic [CLS_W-1:0] r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      r[2*i +: 2] = merge_one(d[2*i +: 2], s[2*i +: 2]);
    end
    return r;
  endfunction

  function automatic logic [ARCH_W-1:0] merge_arch(logic [ARCH_W-1:0] d, logic [ARCH_W-1:0] v);
    logic [ARCH_W-1:0] r;
    if (d == ARCH_NONE) begin
      r = v;
    end else if (d != v) begin
      r = ARCH_MIXED;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ===== hdl/bpfrct_front.sv =====
module bpfrct_front import bpfrct_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [IDX_W-1:0]  stmt_index_i,
  input  logic [1:0]        dest_kind_i,
  input  logic [2:0]        src_kind_i,
  input  logic              plain_assign_i,
  input  logic [3:0]        dest_mem_index_i,
  input  logic [3:0]        src_mem_index_i,
  input  logic              conditional_i,
  input  logic [IDX_W-1:0]  true_offset_i,
  input  logic [IDX_W-1:0]  false_offset_i,
  input  logic [1:0]        compare_kind_i,
  input  logic [ARCH_W-1:0] compare_value_i,
  input  logic              clearing_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  logic              pc_ok;
  logic [SUCC_W-1:0] nxt;
  logic [SUCC_W-1:0] jt;
  logic [SUCC_W-1:0] jf;
  logic              nxt_ok;
  logic              jt_ok;
  logic              jf_ok;
  cmd_t              cmd;

  assign in_ready_o = !q_full_i && !clearing_i;
  assign q_push_o   = in_valid_i && in_ready_o;
  assign q_cmd_o    = cmd;

  assign pc_ok  = 32'(stmt_index_i) < 32'(MAX_STATEMENTS);
  assign nxt    = SUCC_W'(stmt_index_i) + SUCC_W'(1);
  assign jt     = SUCC_W'(stmt_index_i) + SUCC_W'(true_offset_i) + SUCC_W'(1);
  assign jf     = SUCC_W'(stmt_index_i) + SUCC_W'(false_offset_i) + SUCC_W'(1);
  assign nxt_ok = 32'(nxt) < 32'(MAX_STATEMENTS);
  assign jt_ok  = 32'(jt) < 32'(MAX_STATEMENTS);
  assign jf_ok  = 32'(jf) < 32'(MAX_STATEMENTS);

  always_comb begin
    cmd       = '0;
    cmd.op    = op_e'(op_i);
    cmd.pc    = addr_t'(stmt_index_i);
    cmd.pc_ok = pc_ok;
    case (cmd.op)
      OP_ASSIGN: begin
        cmd.succ1    = addr_t'(nxt);
        cmd.succ1_ok = pc_ok && nxt_ok;
        cmd.err      = !pc_ok || !nxt_ok;
        // source class
        if (!plain_assign_i) begin
          cmd.src_cls = CLS_MIXED;
        end else begin
          case (src_kind_i)
            SRC_SYSNR: cmd.src_cls = CLS_SYSNR;
            SRC_ARCH:  cmd.src_cls = CLS_ARCH;
            SRC_A: begin
              cmd.src_en   = 1'b1;
              cmd.src_slot = SLOT_A;
            end
            SRC_X: begin
              cmd.src_en   = 1'b1;
              cmd.src_slot = SLOT_X;
            end
            SRC_MEM: begin
              if (32'(src_mem_index_i) < 32'(SCRATCH_WORDS)) begin
                cmd.src_en   = 1'b1;
                cmd.src_slot = SLOT_MEM + SLOT_W'(src_mem_index_i);
              end else begin
                cmd.src_cls = CLS_MIXED;
              end
            end
            default: cmd.src_cls = CLS_MIXED;
          endcase
        end
        // destination slot
        case (dest_kind_i)
          DST_A: begin
            cmd.dst_en   = 1'b1;
            cmd.dst_slot = SLOT_A;
          end
          DST_X: begin
            cmd.dst_en   = 1'b1;
            cmd.dst_slot = SLOT_X;
          end
          DST_MEM: begin
            cmd.dst_en   = 32'(dest_mem_index_i) < 32'(SCRATCH_WORDS);
            cmd.dst_slot = SLOT_MEM + SLOT_W'(dest_mem_index_i);
          end
          default: cmd.dst_en = 1'b0;
        endcase
      end
      OP_JUMP: begin
        cmd.succ1    = addr_t'(jt);
        cmd.succ1_ok = pc_ok && jt_ok;
        cmd.succ2    = addr_t'(jf);
        cmd.succ2_ok = pc_ok && conditional_i && jf_ok;
        cmd.err      = !pc_ok || !jt_ok || (conditional_i && !jf_ok);
        cmd.cond     = conditional_i;
        cmd.cmp      = compare_kind_i;
        cmd.cval     = compare_value_i;
      end
      OP_RETURN: cmd.err = !pc_ok;
      default:   cmd.err = 1'b0;
    endcase
  end

endmodule

// ===== hdl/bpfrct_queue.sv =====
module bpfrct_queue import bpfrct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/bpfrct_back.sv =====
module bpfrct_back import bpfrct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              entry_arch_we_i,
  input  logic [ARCH_W-1:0] entry_arch_i,
  input  logic              q_empty_i,
  input  cmd_t              q_head_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        operand_class_o,
  output logic [ARCH_W-1:0] known_arch_o,
  output logic              target_error_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_JOIN1 = 3'd3;
  localparam logic [2:0] ST_RD2   = 3'd4;
  localparam logic [2:0] ST_JOIN2 = 3'd5;

  logic [2:0]        state_q, state_d;
  addr_t             clr_cnt_q, clr_cnt_d;
  logic [ARCH_W-1:0] cfg_arch_q;
  logic [ARCH_W-1:0] start_arch_q, start_arch_d;
  cmd_t              cmd_q, cmd_d;
  logic [CLS_W-1:0]  src_cls_q, src_cls_d;
  logic [ARCH_W-1:0] av1_q, av1_d, av2_q, av2_d;
  logic              av1_en_q, av1_en_d, av2_en_q, av2_en_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        opnd_q, opnd_d;
  logic [ARCH_W-1:0] known_q, known_d;
  logic              err_q, err_d;
  logic              out_set;

  entry_t            mem_q [MAX_STATEMENTS];
  entry_t            rdata_q;
  addr_t             raddr;
  addr_t             waddr;
  entry_t            wdata;
  logic              mem_we;

  logic [1:0]        a_cls;
  logic [1:0]        new_cls;
  logic [CLS_W-1:0]  upd_cls;
  entry_t            merged;
  logic              use_av1;

  assign clearing_o      = state_q == ST_CLEAR;
  assign out_valid_o     = out_valid_q;
  assign operand_class_o = opnd_q;
  assign known_arch_o    = known_q;
  assign target_error_o  = err_q;

  // assignment update of the statement's own entry
  always_comb begin
    a_cls   = rdata_q.cls[1:0];
    new_cls = cmd_q.src_en ? rdata_q.cls[{cmd_q.src_slot, 1'b0} +: 2] : cmd_q.src_cls;
    upd_cls = rdata_q.cls;
    if (cmd_q.dst_en) begin
      upd_cls[{cmd_q.dst_slot, 1'b0} +: 2] = new_cls;
    end
  end

  // successor merge
  always_comb begin
    use_av1     = state_q == ST_JOIN1;
    merged.cls  = merge_cls(rdata_q.cls, src_cls_q);
    merged.arch = rdata_q.arch;
    if (use_av1 && av1_en_q) begin
      merged.arch = merge_arch(rdata_q.arch, av1_q);
    end else if (!use_av1 && av2_en_q) begin
      merged.arch = merge_arch(rdata_q.arch, av2_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    start_arch_d = start_arch_q;
    cmd_d        = cmd_q;
    src_cls_d    = src_cls_q;
    av1_d        = av1_q;
    av2_d        = av2_q;
    av1_en_d     = av1_en_q;
    av2_en_d     = av2_en_q;
    q_pop_o      = 1'b0;
    raddr        = cmd_q.succ1;
    waddr        = cmd_q.succ1;
    wdata        = merged;
    mem_we       = 1'b0;
    out_set      = 1'b0;
    opnd_d       = opnd_q;
    known_d      = known_q;
    err_d        = err_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        waddr      = clr_cnt_q;
        wdata.cls  = '0;
        wdata.arch = (clr_cnt_q == addr_t'(1)) ? start_arch_q : ARCH_NONE;
        clr_cnt_d  = clr_cnt_q + addr_t'(1);
        if (clr_cnt_q == addr_t'(MAX_STATEMENTS - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = q_head_i.pc;
        if (!q_empty_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          if (q_head_i.op == OP_START) begin
            out_set      = 1'b1;
            opnd_d       = OPND_NONE;
            known_d      = ARCH_NONE;
            err_d        = 1'b0;
            start_arch_d = cfg_arch_q;
            state_d      = ST_CLEAR;
          end else if (!q_head_i.pc_ok) begin
            out_set = 1'b1;
            opnd_d  = OPND_NONE;
            known_d = ARCH_NONE;
            err_d   = 1'b1;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        out_set   = 1'b1;
        opnd_d    = OPND_NONE;
        known_d   = rdata_q.arch;
        err_d     = cmd_q.err;
        src_cls_d = rdata_q.cls;
        av1_d     = rdata_q.arch;
        av2_d     = rdata_q.arch;
        av1_en_d  = 1'b1;
        av2_en_d  = 1'b1;
        state_d   = ST_IDLE;
        case (cmd_q.op)
          OP_ASSIGN: begin
            mem_we     = 1'b1;
            waddr      = cmd_q.pc;
            wdata.cls  = upd_cls;
            wdata.arch = rdata_q.arch;
            src_cls_d  = upd_cls;
          end
          OP_JUMP: begin
            if (cmd_q.cond) begin
              if (a_cls == CLS_ARCH) begin
                opnd_d = OPND_ARCH;
                case (cmd_q.cmp)
                  CMP_EQ: begin
                    av1_d = cmd_q.cval;
                    av2_d = ARCH_MIXED;
                  end
                  CMP_NE: begin
                    av1_d = ARCH_MIXED;
                    av2_d = cmd_q.cval;
                  end
                  default: begin
                    av1_en_d = 1'b0;
                    av2_en_d = 1'b0;
                  end
                endcase
              end else if (a_cls == CLS_SYSNR) begin
                opnd_d = OPND_SYSNR;
              end
            end
          end
          default: begin
            av1_en_d = 1'b0;
          end
        endcase
        if (cmd_q.op != OP_RETURN) begin
          if (cmd_q.succ1_ok) begin
            raddr   = cmd_q.succ1;
            state_d = ST_JOIN1;
          end else if (cmd_q.succ2_ok) begin
            state_d = ST_RD2;
          end
        end
      end
      ST_JOIN1: begin
        mem_we  = 1'b1;
        waddr   = cmd_q.succ1;
        state_d = cmd_q.succ2_ok ? ST_RD2 : ST_IDLE;
      end
      ST_RD2: begin
        raddr   = cmd_q.succ2;
        state_d = ST_JOIN2;
      end
      ST_JOIN2: begin
        mem_we  = 1'b1;
        waddr   = cmd_q.succ2;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_set || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      cfg_arch_q   <= '0;
      start_arch_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      start_arch_q <= start_arch_d;
      out_valid_q  <= out_valid_d;
      if (entry_arch_we_i) begin
        cfg_arch_q <= entry_arch_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    src_cls_q <= src_cls_d;
    av1_q     <= av1_d;
    av2_q     <= av2_d;
    av1_en_q  <= av1_en_d;
    av2_en_q  <= av2_en_d;
    opnd_q    <= opnd_d;
    known_q   <= known_d;
    err_q     <= err_d;
  end

  // statement table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule

// ===== hdl/bpf_filter_register_class_tracker.sv =====
// flow: an assignment, jump or return is queued, popped in idle while its entry is read,
// and its result registered in exec; a start or an out-of-table statement is answered on the pop
// the queue takes new transactions while earlier ones are processed, until it is full; the next
// is popped only once the result is accepted and any successor merges of a jump are done
// a start and reset both run a clearing pass over all MAX_STATEMENTS (1024) entries of the
// table with in_ready_o low; the entry architecture register resets to 0
module bpf_filter_register_class_tracker import bpfrct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              entry_arch_we_i,
  input  logic [ARCH_W-1:0] entry_arch_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [IDX_W-1:0]  stmt_index_i,
  input  logic [1:0]        dest_kind_i,
  input  logic [2:0]        src_kind_i,
  input  logic              plain_assign_i,
  input  logic [3:0]        dest_mem_index_i,
  input  logic [3:0]        src_mem_index_i,
  input  logic              conditional_i,
  input  logic [IDX_W-1:0]  true_offset_i,
  input  logic [IDX_W-1:0]  false_offset_i,
  input  logic [1:0]        compare_kind_i,
  input  logic [ARCH_W-1:0] compare_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        operand_class_o,
  output logic [ARCH_W-1:0] known_arch_o,
  output logic              target_error_o
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;
  logic clearing;

  bpfrct_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .stmt_index_i     (stmt_index_i),
    .dest_kind_i      (dest_kind_i),
    .src_kind_i       (src_kind_i),
    .plain_assign_i   (plain_assign_i),
    .dest_mem_index_i (dest_mem_index_i),
    .src_mem_index_i  (src_mem_index_i),
    .conditional_i    (conditional_i),
    .true_offset_i    (true_offset_i),
    .false_offset_i   (false_offset_i),
    .compare_kind_i   (compare_kind_i),
    .compare_value_i  (compare_value_i),
    .clearing_i       (clearing),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (q_cmd)
  );

  bpfrct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  bpfrct_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_arch_we_i (entry_arch_we_i),
    .entry_arch_i    (entry_arch_i),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .operand_class_o (operand_class_o),
    .known_arch_o    (known_arch_o),
    .target_error_o  (target_error_o)
  );

endmodule

// ===== hdl/bpfrct_checker.sv =====
module bpfrct_checker import bpfrct_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        operand_class_o,
  input logic [ARCH_W-1:0] known_arch_o,
  input logic              target_error_o
);

  localparam int PENDING_MAX = QUEUE_DEPTH + 1;
  localparam int PEND_W      = $clog2(PENDING_MAX + 2);

  logic [PEND_W-1:0] pending_q, pending_d;
  logic              in_acc;
  logic              out_acc;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign pending_d = pending_q + PEND_W'(in_acc) - PEND_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(operand_class_o)
      && $stable(known_arch_o) && $stable(target_error_o))
    else $error("result changed while stalled");

  // no result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without pending transaction");

  // queue plus output register bound the number in flight
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) <= PENDING_MAX)
    else $error("too many transactions in flight");

  // clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o)
    else $error("ready during clearing pass after reset");

endmodule

bind bpf_filter_register_class_tracker bpfrct_checker u_checker (.*);
